>>> hw/rtl/imtef_pkg.sv
// Shared types and constants for the input modality tracker.
`timescale 1ns / 1ps

package imtef_pkg;

    localparam int KEY_ENTRIES_DEF = 256;
    localparam int TIME_BITS_DEF   = 48;
    localparam int CODE_W          = 8;
    localparam int COUNT_W         = 8;
    localparam int NOW_W           = 48;
    localparam int WIN_W           = 32;
    localparam int QUEUE_DEPTH     = 2;    // power of two

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    localparam logic [1:0] DEV_KEYBOARD = 2'd0;
    localparam logic [1:0] DEV_MOUSE    = 2'd1;
    localparam logic [1:0] DEV_GAMEPAD  = 2'd2;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_MARK,
        KIND_EVENT
    } item_kind_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [CODE_W-1:0]   code;
        logic [COUNT_W-1:0]  count;
        logic [1:0]          device;
        logic                is_button;
        logic                last;
        logic                lookup;    // keyboard button with an in-range scancode
    } item_ctrl_t;

    localparam int CTRL_W = $bits(item_ctrl_t);

endpackage

>>> hw/rtl/imtef_front.sv
// Front end: classifies each input item and precomputes its saturated expiry.
`timescale 1ns / 1ps

module imtef_front #(
    parameter int KEY_ENTRIES = imtef_pkg::KEY_ENTRIES_DEF,
    parameter int TIME_BITS   = imtef_pkg::TIME_BITS_DEF,
    parameter int DATA_W      = imtef_pkg::CTRL_W + 2 * TIME_BITS
) (
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [imtef_pkg::NOW_W-1:0]   now_ms,
    input  logic [imtef_pkg::CODE_W-1:0]  scancode,
    input  logic [imtef_pkg::COUNT_W-1:0] add_count,
    input  logic [imtef_pkg::WIN_W-1:0]   window_ms,
    input  logic [1:0]                    device,
    input  logic                          is_button,
    input  logic                          last_in_batch,
    output logic                          q_push,
    output logic [DATA_W-1:0]             q_data,
    input  logic                          q_ready
);
    import imtef_pkg::*;

    localparam int SUM_W = ((TIME_BITS > NOW_W) ? TIME_BITS : NOW_W) + 1;
    localparam logic [SUM_W-1:0] TMASK = (SUM_W'(1) << TIME_BITS) - SUM_W'(1);

    logic [SUM_W-1:0]     now_w;
    logic [SUM_W-1:0]     sum_w;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] exp_t;
    logic                 in_range;
    item_ctrl_t           ctrl;

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

    assign now_w = SUM_W'(now_ms) & TMASK;
    assign sum_w = now_w + SUM_W'(window_ms);
    assign now_t = now_w[TIME_BITS-1:0];
    assign exp_t = (sum_w > TMASK) ? TMASK[TIME_BITS-1:0] : sum_w[TIME_BITS-1:0];

    assign in_range = ({1'b0, scancode} < (CODE_W + 1)'(KEY_ENTRIES));

    always_comb
    begin
        ctrl.code      = scancode;
        ctrl.count     = add_count;
        ctrl.device    = device;
        ctrl.is_button = is_button;
        ctrl.last      = last_in_batch;
        ctrl.lookup    = in_range && is_button && (device == DEV_KEYBOARD);
        if (opcode == OP_EVENT)
        begin
            ctrl.kind = KIND_EVENT;
        end
        else if ((add_count != '0) && in_range)
        begin
            ctrl.kind = KIND_MARK;
        end
        else
        begin
            ctrl.kind = KIND_NOP;
        end
    end

    assign q_data = {ctrl, now_t, exp_t};

endmodule

>>> hw/rtl/imtef_queue.sv
// Short FIFO between the front end and the table sequencer.
`timescale 1ns / 1ps

module imtef_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              push_ready,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              pop_valid
);
    import imtef_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;

    assign push_ready = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/imtef_back.sv
// Back end: scancode table read-modify-write, window and batch mode state.
`timescale 1ns / 1ps

module imtef_back #(
    parameter int KEY_ENTRIES = imtef_pkg::KEY_ENTRIES_DEF,
    parameter int TIME_BITS   = imtef_pkg::TIME_BITS_DEF,
    parameter int DATA_W      = imtef_pkg::CTRL_W + 2 * TIME_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  logic [DATA_W-1:0] q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              gamepad_mode,
    output logic              mode_changed,
    output logic              event_ignored
);
    import imtef_pkg::*;

    localparam int IDX_W = $clog2(KEY_ENTRIES);
    localparam int ENT_W = COUNT_W + TIME_BITS;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t               state_reg;
    item_ctrl_t           cur_ctrl_reg;
    logic [TIME_BITS-1:0] cur_now_reg;
    logic [TIME_BITS-1:0] cur_exp_reg;
    logic [TIME_BITS-1:0] window_reg, window_next;
    logic                 mode_reg, mode_next;
    logic                 choice_valid_reg, choice_valid_next;
    logic                 choice_reg, choice_next;
    logic                 out_valid_reg;
    logic                 gamepad_mode_reg;
    logic                 mode_changed_reg, mode_changed_next;
    logic                 event_ignored_reg, event_ignored_next;
    logic [KEY_ENTRIES-1:0] entry_valid_reg;

    logic [ENT_W-1:0]     table_mem [KEY_ENTRIES];
    logic [ENT_W-1:0]     rd_data_reg;

    item_ctrl_t           q_ctrl;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     cur_idx;
    logic                 out_free;
    logic                 ent_valid;
    logic [COUNT_W-1:0]   ent_cnt;
    logic [TIME_BITS-1:0] ent_exp;
    logic [COUNT_W:0]     cnt_sum;
    logic                 mem_we;
    logic [COUNT_W-1:0]   wr_cnt;
    logic [TIME_BITS-1:0] wr_exp;
    logic                 consumed;
    logic                 win_active;

    assign q_ctrl  = item_ctrl_t'(q_data[DATA_W-1 -: CTRL_W]);
    assign rd_idx  = q_ctrl.code[IDX_W-1:0];
    assign cur_idx = cur_ctrl_reg.code[IDX_W-1:0];

    // output slot is free once the waiting result leaves this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid && out_free;

    // never-written entries read as zero
    assign ent_valid = entry_valid_reg[cur_idx];
    assign ent_cnt   = ent_valid ? rd_data_reg[ENT_W-1 -: COUNT_W] : '0;
    assign ent_exp   = ent_valid ? rd_data_reg[TIME_BITS-1:0] : '0;
    assign cnt_sum   = {1'b0, ent_cnt} + {1'b0, cur_ctrl_reg.count};

    always_comb
    begin
        mem_we             = 1'b0;
        wr_cnt             = ent_cnt;
        wr_exp             = ent_exp;
        window_next        = window_reg;
        mode_next          = mode_reg;
        choice_valid_next  = choice_valid_reg;
        choice_next        = choice_reg;
        mode_changed_next  = 1'b0;
        event_ignored_next = 1'b0;
        consumed           = 1'b0;
        win_active         = 1'b0;
        unique case (cur_ctrl_reg.kind)
            KIND_MARK:
            begin
                mem_we = 1'b1;
                wr_cnt = cnt_sum[COUNT_W] ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
                wr_exp = cur_exp_reg;
                if (window_reg < cur_exp_reg)
                begin
                    window_next = cur_exp_reg;
                end
            end
            KIND_EVENT:
            begin
                if (cur_ctrl_reg.device == DEV_KEYBOARD)
                begin
                    if (cur_ctrl_reg.lookup && (ent_cnt != '0))
                    begin
                        mem_we = 1'b1;
                        if ((ent_exp != '0) && (cur_now_reg > ent_exp))
                        begin
                            // stale mark: drop it, event is not consumed
                            wr_cnt = '0;
                            wr_exp = '0;
                        end
                        else
                        begin
                            consumed = 1'b1;
                            wr_cnt   = ent_cnt - COUNT_W'(1);
                            if (ent_cnt == COUNT_W'(1))
                            begin
                                wr_exp = '0;
                            end
                        end
                    end
                    if (!consumed && (window_reg != '0))
                    begin
                        if (cur_now_reg > window_reg)
                        begin
                            window_next = '0;
                        end
                        else
                        begin
                            win_active = 1'b1;
                        end
                    end
                    if (consumed || win_active)
                    begin
                        event_ignored_next = 1'b1;
                    end
                    else
                    begin
                        choice_next       = 1'b0;
                        choice_valid_next = 1'b1;
                    end
                end
                else if (cur_ctrl_reg.device == DEV_MOUSE)
                begin
                    choice_next       = 1'b0;
                    choice_valid_next = 1'b1;
                end
                else if (cur_ctrl_reg.device == DEV_GAMEPAD)
                begin
                    choice_next       = 1'b1;
                    choice_valid_next = 1'b1;
                end
                if (cur_ctrl_reg.last)
                begin
                    if (choice_valid_next)
                    begin
                        mode_changed_next = (mode_reg != choice_next);
                        mode_next         = choice_next;
                    end
                    choice_valid_next = 1'b0;
                    choice_next       = 1'b0;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cur_ctrl_reg      <= '0;
            cur_now_reg       <= '0;
            cur_exp_reg       <= '0;
            window_reg        <= '0;
            mode_reg          <= 1'b0;
            choice_valid_reg  <= 1'b0;
            choice_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
            gamepad_mode_reg  <= 1'b0;
            mode_changed_reg  <= 1'b0;
            event_ignored_reg <= 1'b0;
            entry_valid_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        cur_ctrl_reg <= q_ctrl;
                        cur_now_reg  <= q_data[2*TIME_BITS-1 -: TIME_BITS];
                        cur_exp_reg  <= q_data[TIME_BITS-1:0];
                        state_reg    <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    window_reg        <= window_next;
                    mode_reg          <= mode_next;
                    choice_valid_reg  <= choice_valid_next;
                    choice_reg        <= choice_next;
                    out_valid_reg     <= 1'b1;
                    gamepad_mode_reg  <= mode_next;
                    mode_changed_reg  <= mode_changed_next;
                    event_ignored_reg <= event_ignored_next;
                    if (mem_we)
                    begin
                        entry_valid_reg[cur_idx] <= 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // read on pop, write back in the cycle after; the two never coincide
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_EXEC) && mem_we)
        begin
            table_mem[cur_idx] <= {wr_cnt, wr_exp};
        end
        if (q_pop)
        begin
            rd_data_reg <= table_mem[rd_idx];
        end
    end

    assign out_valid     = out_valid_reg;
    assign gamepad_mode  = gamepad_mode_reg;
    assign mode_changed  = mode_changed_reg;
    assign event_ignored = event_ignored_reg;

endmodule

>>> hw/rtl/input_modality_tracker_with_echo_filter_unit.sv
// Top level of the input modality tracker with synthetic-key echo filter.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_ready   opcode, now_ms, scancode, add_count,
//                                             window_ms, device, is_button, last_in_batch
//   result   out        out_valid / out_ready gamepad_mode, mode_changed, event_ignored
//
// The front end takes an item per cycle into a 2-entry queue while the queue has room.
// The back end handles one item at a time: scancode table read, then write-back.
// One result per item; a new item is read only once the waiting result leaves the output register.
// Reset is immediate: per-entry valid bits make the table read as zero, no clearing pass.
// A stalled output holds the back end; the queue keeps the front end taking items until it is full.
`timescale 1ns / 1ps

module input_modality_tracker_with_echo_filter_unit #(
    parameter int KEY_ENTRIES = imtef_pkg::KEY_ENTRIES_DEF,
    parameter int TIME_BITS   = imtef_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [imtef_pkg::NOW_W-1:0]   now_ms,
    input  logic [imtef_pkg::CODE_W-1:0]  scancode,
    input  logic [imtef_pkg::COUNT_W-1:0] add_count,
    input  logic [imtef_pkg::WIN_W-1:0]   window_ms,
    input  logic [1:0]                    device,
    input  logic                          is_button,
    input  logic                          last_in_batch,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          gamepad_mode,
    output logic                          mode_changed,
    output logic                          event_ignored
);
    import imtef_pkg::*;

    localparam int DATA_W = CTRL_W + 2 * TIME_BITS;

    logic              q_push;
    logic              q_ready;
    logic [DATA_W-1:0] q_in_data;
    logic              q_pop;
    logic              q_valid;
    logic [DATA_W-1:0] q_out_data;

    imtef_front #(
        .KEY_ENTRIES (KEY_ENTRIES),
        .TIME_BITS   (TIME_BITS),
        .DATA_W      (DATA_W)
    ) u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .now_ms        (now_ms),
        .scancode      (scancode),
        .add_count     (add_count),
        .window_ms     (window_ms),
        .device        (device),
        .is_button     (is_button),
        .last_in_batch (last_in_batch),
        .q_push        (q_push),
        .q_data        (q_in_data),
        .q_ready       (q_ready)
    );

    imtef_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in_data),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_data   (q_out_data),
        .pop_valid  (q_valid)
    );

    imtef_back #(
        .KEY_ENTRIES (KEY_ENTRIES),
        .TIME_BITS   (TIME_BITS),
        .DATA_W      (DATA_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_out_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gamepad_mode  (gamepad_mode),
        .mode_changed  (mode_changed),
        .event_ignored (event_ignored)
    );

endmodule
